[hdl/assert_macros.svh]
// Assertion helpers included by the sequencer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/tfas_pkg.sv]
`default_nettype none
package tfas_pkg;

  localparam int unsigned SLOT_COUNT_DEF  = 16;
  localparam int unsigned TABLE_DEPTH_DEF = 32;

  localparam logic [7:0] END_CODE = 8'hff;
  localparam logic [7:0] WAIT_MAX = 8'hff;

  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_WRITE   = 2'd1;
  localparam logic [1:0] KIND_BIND    = 2'd2;
  localparam logic [1:0] KIND_RELEASE = 2'd3;

  localparam logic [1:0] EV_XFER  = 2'd0;
  localparam logic [1:0] EV_BOUND = 2'd1;
  localparam logic [1:0] EV_BUSY  = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [4:0]  entry_index;
    logic [7:0]  entry_pattern;
    logic [7:0]  entry_hold;
    logic [18:0] target_addr;
    logic [19:0] transfer_bytes;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [3:0]  out_slot;
    logic [18:0] dest_addr;
    logic [7:0]  new_pattern;
    logic [19:0] byte_count;
    logic        last;
  } out_item_t;

  typedef enum logic [3:0] {
    COND_ALWAYS,
    COND_NEVER,
    COND_NO_INPUT,
    COND_KIND_TICK,
    COND_KIND_BIND,
    COND_KIND_WRITE,
    COND_INACTIVE,
    COND_HOLD_GT_WAIT,
    COND_WRAP_AT_END,
    COND_END_CODE,
    COND_MORE_SLOTS
  } cond_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_RELEASE,
    ACT_WRITE,
    ACT_BIND,
    ACT_RD_HOLD,
    ACT_HOLD_EVAL,
    ACT_ADVANCE,
    ACT_RD_ZERO,
    ACT_TAKE_PAT,
    ACT_PUSH,
    ACT_NEXT_SLOT,
    ACT_FLUSH
  } act_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_OUT,
    STALL_PEND
  } stall_sel_t;

  typedef logic [4:0] step_t;

  localparam step_t ST_IDLE     = 5'd0;
  localparam step_t ST_DISP_T   = 5'd1;
  localparam step_t ST_DISP_B   = 5'd2;
  localparam step_t ST_DISP_W   = 5'd3;
  localparam step_t ST_RELEASE  = 5'd4;
  localparam step_t ST_WRITE    = 5'd5;
  localparam step_t ST_BIND     = 5'd6;
  localparam step_t ST_T_CHECK  = 5'd7;
  localparam step_t ST_T_HOLD   = 5'd8;
  localparam step_t ST_T_NEXTRD = 5'd9;
  localparam step_t ST_T_PAT    = 5'd10;
  localparam step_t ST_T_ADV    = 5'd11;
  localparam step_t ST_T_RD0    = 5'd12;
  localparam step_t ST_T_TAKE0  = 5'd13;
  localparam step_t ST_T_PUSH   = 5'd14;
  localparam step_t ST_T_NEXT   = 5'd15;
  localparam step_t ST_T_FLUSH  = 5'd16;

  typedef struct packed {
    cond_t      cond;
    step_t      target;
    stall_sel_t stall_sel;
    act_t       act;
  } ctrl_word_t;

  typedef struct packed {
    logic       in_valid;
    logic [1:0] kind;
    logic       inactive;
    logic       hold_gt_wait;
    logic       wrap_at_end;
    logic       end_code;
    logic       more_slots;
    logic       out_free;
    logic       pend_valid;
  } status_t;

  typedef struct packed {
    act_t act;
    logic idle;
  } ctrl_t;

  // Control store. A true condition jumps to target, otherwise the step
  // counter moves on by one; a selected stall that is not free holds the step.
  function automatic ctrl_word_t prog_word(step_t s);
    ctrl_word_t w;
    w = '{cond: COND_ALWAYS, target: ST_IDLE, stall_sel: STALL_NONE, act: ACT_NONE};
    case (s)
      ST_IDLE:     w = '{COND_NO_INPUT,     ST_IDLE,    STALL_NONE, ACT_NONE};
      ST_DISP_T:   w = '{COND_KIND_TICK,    ST_T_CHECK, STALL_NONE, ACT_NONE};
      ST_DISP_B:   w = '{COND_KIND_BIND,    ST_BIND,    STALL_NONE, ACT_NONE};
      ST_DISP_W:   w = '{COND_KIND_WRITE,   ST_WRITE,   STALL_NONE, ACT_NONE};
      ST_RELEASE:  w = '{COND_ALWAYS,       ST_IDLE,    STALL_NONE, ACT_RELEASE};
      ST_WRITE:    w = '{COND_ALWAYS,       ST_IDLE,    STALL_NONE, ACT_WRITE};
      ST_BIND:     w = '{COND_ALWAYS,       ST_IDLE,    STALL_OUT,  ACT_BIND};
      ST_T_CHECK:  w = '{COND_INACTIVE,     ST_T_NEXT,  STALL_NONE, ACT_RD_HOLD};
      ST_T_HOLD:   w = '{COND_HOLD_GT_WAIT, ST_T_NEXT,  STALL_NONE, ACT_HOLD_EVAL};
      ST_T_NEXTRD: w = '{COND_WRAP_AT_END,  ST_T_RD0,   STALL_NONE, ACT_NONE};
      ST_T_PAT:    w = '{COND_END_CODE,     ST_T_RD0,   STALL_NONE, ACT_NONE};
      ST_T_ADV:    w = '{COND_ALWAYS,       ST_T_PUSH,  STALL_NONE, ACT_ADVANCE};
      ST_T_RD0:    w = '{COND_NEVER,        ST_IDLE,    STALL_NONE, ACT_RD_ZERO};
      ST_T_TAKE0:  w = '{COND_NEVER,        ST_IDLE,    STALL_NONE, ACT_TAKE_PAT};
      ST_T_PUSH:   w = '{COND_NEVER,        ST_IDLE,    STALL_PEND, ACT_PUSH};
      ST_T_NEXT:   w = '{COND_MORE_SLOTS,   ST_T_CHECK, STALL_NONE, ACT_NEXT_SLOT};
      ST_T_FLUSH:  w = '{COND_ALWAYS,       ST_IDLE,    STALL_PEND, ACT_FLUSH};
      default:     w = '{COND_ALWAYS,       ST_IDLE,    STALL_NONE, ACT_NONE};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

[hdl/texture_frame_animation_sequencer.sv]
`default_nettype none
// Microcoded slot sequencer over one shared pattern/hold table memory.
// Items are dispatched by kind; a bind item gives one result, a write or release item none.
// A tick visits every slot in turn: a slot is skipped when inactive, holds its pattern while
// its hold exceeds its wait count, and otherwise advances, wrapping to entry zero at the table
// end or on an end code. The table memory has a single read port. One item at a time.
// Reset (synchronous, active low) clears all slots to inactive; the table memory is not cleared.
module texture_frame_animation_sequencer
  import tfas_pkg::*;
#(
  parameter int unsigned SLOT_COUNT  = SLOT_COUNT_DEF,
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

`include "assert_macros.svh"

  localparam int unsigned SW        = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned PW        = $clog2(TABLE_DEPTH);
  localparam int unsigned MEM_DEPTH = SLOT_COUNT * TABLE_DEPTH;
  localparam int unsigned AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam logic [SW:0] SLOT_END  = (SW+1)'(SLOT_COUNT);
  localparam logic [PW:0] POS_END   = (PW+1)'(TABLE_DEPTH);

  status_t status;
  ctrl_t   ctrl;

  tfas_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  // Table memory: pattern in the upper byte, hold in the lower byte.
  logic [15:0]   tbl_mem [MEM_DEPTH];
  logic [15:0]   rd_r;
  logic [AW-1:0] mem_addr;
  logic [15:0]   mem_wdata;
  logic          mem_we;
  logic          mem_re;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_r <= tbl_mem[mem_addr];
    end
  end

  // Per-slot state, read and written only at the current slot outside of reset.
  logic          slot_active_r [SLOT_COUNT];
  logic [PW-1:0] slot_pos_r    [SLOT_COUNT];
  logic [7:0]    slot_wait_r   [SLOT_COUNT];
  logic [18:0]   slot_dest_r   [SLOT_COUNT];
  logic [19:0]   slot_bytes_r  [SLOT_COUNT];

  in_item_t      in_r;
  logic [SW-1:0] cur_slot_r, cur_slot_nxt;
  logic          slot_ok_r;
  logic [7:0]    cand_pat_r, cand_pat_nxt;
  out_item_t     pend_r, pend_nxt;
  logic          pend_valid_r, pend_valid_nxt;
  out_item_t     out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic          cur_active, cur_active_nxt;
  logic [PW-1:0] cur_pos, cur_pos_nxt;
  logic [7:0]    cur_wait, cur_wait_nxt;
  logic          slot_we;
  logic          bind_we;
  logic [PW:0]   pos_inc;
  logic [AW-1:0] base_addr;
  logic          out_free;
  logic          accept;
  logic          push;
  out_item_t     push_item;

  assign accept    = in_valid && ctrl.idle;
  assign in_stall  = !ctrl.idle;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign cur_active = slot_active_r[cur_slot_r];
  assign cur_pos    = slot_pos_r[cur_slot_r];
  assign cur_wait   = slot_wait_r[cur_slot_r];
  assign pos_inc    = {1'b0, cur_pos} + 1'b1;
  assign base_addr  = AW'(AW'(cur_slot_r) * AW'(TABLE_DEPTH));

  always_comb begin
    status.in_valid     = in_valid;
    status.kind         = in_r.kind;
    status.inactive     = !cur_active;
    status.hold_gt_wait = (rd_r[7:0] > cur_wait);
    status.wrap_at_end  = (pos_inc >= POS_END);
    status.end_code     = (rd_r[15:8] == END_CODE);
    status.more_slots   = (({1'b0, cur_slot_r} + 1'b1) < SLOT_END);
    status.out_free     = out_free;
    status.pend_valid   = pend_valid_r;
  end

  always_comb begin
    cur_slot_nxt   = cur_slot_r;
    cand_pat_nxt   = cand_pat_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    cur_active_nxt = cur_active;
    cur_pos_nxt    = cur_pos;
    cur_wait_nxt   = cur_wait;
    slot_we        = 1'b0;
    bind_we        = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_addr       = AW'(base_addr + AW'(cur_pos));
    mem_wdata      = {in_r.entry_pattern, in_r.entry_hold};
    push           = 1'b0;
    push_item      = pend_r;

    case (ctrl.act)
      ACT_NONE: begin
      end
      ACT_RELEASE: begin
        if (slot_ok_r) begin
          cur_active_nxt = 1'b0;
          cur_pos_nxt    = '0;
          cur_wait_nxt   = '0;
          slot_we        = 1'b1;
        end
      end
      ACT_WRITE: begin
        mem_addr = AW'(base_addr + AW'(in_r.entry_index));
        mem_we   = slot_ok_r && (32'(in_r.entry_index) < TABLE_DEPTH);
      end
      ACT_BIND: begin
        push      = 1'b1;
        push_item = '{event_res: EV_BUSY, out_slot: in_r.slot, dest_addr: '0,
                      new_pattern: '0, byte_count: '0, last: 1'b1};
        if (slot_ok_r && !cur_active) begin
          push_item.event_res = EV_BOUND;
          cur_active_nxt      = 1'b1;
          cur_pos_nxt         = '0;
          cur_wait_nxt        = '0;
          slot_we             = 1'b1;
          bind_we             = 1'b1;
        end
      end
      ACT_RD_HOLD: begin
        mem_re = 1'b1;
      end
      ACT_HOLD_EVAL: begin
        slot_we = 1'b1;
        if (rd_r[7:0] > cur_wait) begin
          if (cur_wait < WAIT_MAX) begin
            cur_wait_nxt = cur_wait + 1'b1;
          end
        end else begin
          cur_wait_nxt = '0;
          mem_addr     = AW'(base_addr + AW'(pos_inc));
          mem_re       = (pos_inc < POS_END);
        end
      end
      ACT_ADVANCE: begin
        cur_pos_nxt  = PW'(pos_inc);
        slot_we      = 1'b1;
        cand_pat_nxt = rd_r[15:8];
      end
      ACT_RD_ZERO: begin
        cur_pos_nxt = '0;
        slot_we     = 1'b1;
        mem_addr    = base_addr;
        mem_re      = 1'b1;
      end
      ACT_TAKE_PAT: begin
        cand_pat_nxt = rd_r[15:8];
      end
      ACT_PUSH: begin
        // The previous transfer leaves now; only the newest is held back so
        // that the final one of the tick can be marked last.
        push           = pend_valid_r;
        push_item      = pend_r;
        pend_valid_nxt = 1'b1;
        pend_nxt       = '{event_res: EV_XFER, out_slot: 4'(cur_slot_r),
                           dest_addr: slot_dest_r[cur_slot_r], new_pattern: cand_pat_r,
                           byte_count: slot_bytes_r[cur_slot_r], last: 1'b0};
      end
      ACT_NEXT_SLOT: begin
        if (status.more_slots) begin
          cur_slot_nxt = SW'(cur_slot_r + 1'b1);
        end
      end
      ACT_FLUSH: begin
        push           = pend_valid_r;
        push_item      = pend_r;
        push_item.last = 1'b1;
        pend_valid_nxt = 1'b0;
      end
      default: begin
      end
    endcase

    if (accept) begin
      pend_valid_nxt = 1'b0;
      if (in_data.kind == KIND_TICK || 32'(in_data.slot) >= SLOT_COUNT) begin
        cur_slot_nxt = '0;
      end else begin
        cur_slot_nxt = SW'(in_data.slot);
      end
    end

    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (push) begin
      out_nxt       = push_item;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      cur_slot_r   <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_active_r[i] <= 1'b0;
        slot_pos_r[i]    <= '0;
        slot_wait_r[i]   <= '0;
      end
    end else begin
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      cur_slot_r   <= cur_slot_nxt;
      if (slot_we) begin
        slot_active_r[cur_slot_r] <= cur_active_nxt;
        slot_pos_r[cur_slot_r]    <= cur_pos_nxt;
        slot_wait_r[cur_slot_r]   <= cur_wait_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r      <= out_nxt;
    pend_r     <= pend_nxt;
    cand_pat_r <= cand_pat_nxt;
    if (accept) begin
      in_r      <= in_data;
      slot_ok_r <= (32'(in_data.slot) < SLOT_COUNT);
    end
    if (bind_we) begin
      slot_dest_r[cur_slot_r]  <= in_r.target_addr;
      slot_bytes_r[cur_slot_r] <= in_r.transfer_bytes;
    end
  end

  `ASSERT_CLK(a_pend_only_tick, pend_valid_r |-> (in_r.kind == KIND_TICK), "pending transfer outside a tick")
  `ASSERT_CLK(a_pos_in_table, ({1'b0, cur_pos} < POS_END), "slot position beyond table end")
  `ASSERT_CLK(a_idle_slot_clear, !cur_active |-> (cur_wait == 8'd0) && (cur_pos == '0), "inactive slot holds state")
  `ASSERT_CLK(a_bind_is_last, out_valid_r && (out_r.event_res != EV_XFER) |-> out_r.last, "bind result not last")
  `ASSERT_CLK_ALWAYS(a_reset_empty, !rst_n |=> !out_valid_r, "result valid after reset")

endmodule
`default_nettype wire

[hdl/tfas_seq.sv]
`default_nettype none
module tfas_seq
  import tfas_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire status_t status,
  output ctrl_t        ctrl
);

  step_t      step_r;
  step_t      step_nxt;
  ctrl_word_t word;
  logic       go;
  logic       cond_true;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_comb begin
    word = prog_word(step_r);

    case (word.stall_sel)
      STALL_NONE: go = 1'b1;
      STALL_OUT:  go = status.out_free;
      STALL_PEND: go = !status.pend_valid || status.out_free;
      default:    go = 1'b1;
    endcase

    case (word.cond)
      COND_ALWAYS:       cond_true = 1'b1;
      COND_NEVER:        cond_true = 1'b0;
      COND_NO_INPUT:     cond_true = !status.in_valid;
      COND_KIND_TICK:    cond_true = (status.kind == KIND_TICK);
      COND_KIND_BIND:    cond_true = (status.kind == KIND_BIND);
      COND_KIND_WRITE:   cond_true = (status.kind == KIND_WRITE);
      COND_INACTIVE:     cond_true = status.inactive;
      COND_HOLD_GT_WAIT: cond_true = status.hold_gt_wait;
      COND_WRAP_AT_END:  cond_true = status.wrap_at_end;
      COND_END_CODE:     cond_true = status.end_code;
      COND_MORE_SLOTS:   cond_true = status.more_slots;
      default:           cond_true = 1'b0;
    endcase

    if (!go) begin
      step_nxt = step_r;
    end else if (cond_true) begin
      step_nxt = word.target;
    end else begin
      step_nxt = step_t'(step_r + 1'b1);
    end

    ctrl.act  = go ? word.act : ACT_NONE;
    ctrl.idle = (step_r == ST_IDLE);
  end

endmodule
`default_nettype wire
